// ===== rtl/lbeg_pkg.sv =====
// ----------------------------------------------------------------------------
// LED brightness effect generator package
// Style codes, register indexes, state/control types and the constant
// sine and log-ramp lookup tables shared by the effect engine.
// ----------------------------------------------------------------------------
package lbeg_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_REFRESH_PERIOD  = 2'd0;
    localparam logic [1:0] REG_CHANNEL_ENABLED = 2'd1;
    localparam logic [1:0] REG_EFFECT_STYLE    = 2'd2;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned PHASE_W  = 16;

    localparam logic [PHASE_W-1:0] STEP_FAST = 16'd1043;
    localparam logic [PHASE_W-1:0] STEP_SLOW = 16'd522;
    localparam logic [15:0]        LFSR_MASK = 16'hB400;
    localparam logic [15:0]        LFSR_SEED = 16'hACE1;

    // Reciprocal of 5 for 16-bit dividends: x / 5 == (x * RECIP_5) >> 18
    localparam logic [15:0] RECIP_5       = 16'hCCCD;
    localparam int unsigned RECIP_5_SHIFT = 18;

    typedef enum logic [2:0] {
        STYLE_TRIANGLE  = 3'd0,
        STYLE_EXPDIM    = 3'd1,
        STYLE_SINE_FAST = 3'd2,
        STYLE_SINE_SLOW = 3'd3,
        STYLE_LOG       = 3'd4,
        STYLE_STEPDIM   = 3'd5,
        STYLE_ZIGZAG    = 3'd6,
        STYLE_LINDIM    = 3'd7
    } style_t;

    // Control from the divider to the effect engine
    typedef struct packed {
        logic   advance;
        style_t style;
    } effect_ctrl_t;

    typedef logic [LEVEL_W-1:0] level_rom_t [256];
    typedef logic [7:0]         quarter_rom_t [65];

    localparam quarter_rom_t QUARTER_SINE = '{
        8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
        8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
        8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
        8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
        8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
        8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
        8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
        8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255,
        8'd255
    };

    // Full-turn sine, offset to 0..255
    function automatic level_rom_t build_sine_rom();
        level_rom_t  rom;
        int unsigned q;
        int unsigned quad;
        int unsigned s;
        int unsigned v;
        for (int i = 0; i < 256; i++) begin
            q    = i % 64;
            quad = (i / 64) % 4;
            s    = (quad % 2 == 1) ? int'(QUARTER_SINE[64 - q]) : int'(QUARTER_SINE[q]);
            v    = (quad < 2) ? (255 + s) / 2 : (255 - s) / 2;
            rom[i] = v[LEVEL_W-1:0];
        end
        return rom;
    endfunction

    // 255 * log2(1 + step) / 8, log2 by truncating square-and-compare
    function automatic level_rom_t build_log_rom();
        level_rom_t      rom;
        longint unsigned n;
        longint unsigned e;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned v;
        for (int i = 0; i < 256; i++) begin
            n = longint'(i) + 1;
            e = 0;
            for (int b = 0; b < 8; b++) begin
                if ((n >> (e + 1)) != 0) e = e + 1;
            end
            m    = n << (30 - e);
            frac = 0;
            for (int k = 0; k < 16; k++) begin
                m    = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    frac = frac | 64'd1;
                    m    = m >> 1;
                end
            end
            v = (64'd255 * ((e << 16) | frac)) >> 19;
            rom[i] = v[LEVEL_W-1:0];
        end
        return rom;
    endfunction

    localparam level_rom_t SINE_ROM = build_sine_rom();
    localparam level_rom_t LOG_ROM  = build_log_rom();

endpackage

// ===== rtl/lbeg_effect.sv =====
// ----------------------------------------------------------------------------
// LED effect engine
// Holds the per-style state and the PWM level; advances the selected style
// by one step when told to and presents the level that results.
// ----------------------------------------------------------------------------
module lbeg_effect
    import lbeg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  effect_ctrl_t         ctrl,
    output logic [LEVEL_W-1:0]   level_next,
    output logic [LEVEL_W-1:0]   level
);

    logic [LEVEL_W-1:0] pwm_level_reg,  pwm_level_next;
    logic               tri_rising_reg, tri_rising_next;
    logic [LEVEL_W-1:0] expdim_reg,     expdim_next;
    logic [PHASE_W-1:0] phase_fast_reg, phase_fast_next;
    logic [PHASE_W-1:0] phase_slow_reg, phase_slow_next;
    logic [7:0]         log_step_reg,   log_step_next;
    logic [LEVEL_W-1:0] stepdim_reg,    stepdim_next;
    logic [15:0]        lfsr_reg,       lfsr_next;
    logic [LEVEL_W-1:0] zigzag_reg,     zigzag_next;
    logic               zz_rising_reg,  zz_rising_next;
    logic [LEVEL_W-1:0] lindim_reg,     lindim_next;

    logic [LEVEL_W-1:0] tri_val;
    logic [LEVEL_W-1:0] zz_val;
    logic [15:0]        lfsr_step;
    logic [29:0]        quot_prod;
    logic [11:0]        quot;
    logic [15:0]        rem20;
    logic [4:0]         dim_step;

    // Random step: advance LFSR, then (lfsr % 20) + 1 via reciprocal of 5
    always_comb begin
        lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : 16'd0);
        quot_prod = {2'b00, lfsr_step[15:2]} * RECIP_5;
        quot      = quot_prod[RECIP_5_SHIFT +: 12];
        rem20     = lfsr_step - ({quot, 4'b0000} + {2'b00, quot, 2'b00});
        dim_step  = rem20[4:0] + 5'd1;
    end

    always_comb begin
        pwm_level_next  = pwm_level_reg;
        tri_rising_next = tri_rising_reg;
        expdim_next     = expdim_reg;
        phase_fast_next = phase_fast_reg;
        phase_slow_next = phase_slow_reg;
        log_step_next   = log_step_reg;
        stepdim_next    = stepdim_reg;
        lfsr_next       = lfsr_reg;
        zigzag_next     = zigzag_reg;
        zz_rising_next  = zz_rising_reg;
        lindim_next     = lindim_reg;

        tri_val = tri_rising_reg ? pwm_level_reg + 8'd1 : pwm_level_reg - 8'd1;
        zz_val  = zz_rising_reg ? zigzag_reg + 8'd5 : zigzag_reg - 8'd5;

        if (ctrl.advance) begin
            case (ctrl.style)
                STYLE_TRIANGLE: begin
                    pwm_level_next = tri_val;
                    if (tri_rising_reg && tri_val == 8'd255) tri_rising_next = 1'b0;
                    if (!tri_rising_reg && tri_val == 8'd0) tri_rising_next = 1'b1;
                end
                STYLE_EXPDIM: begin
                    if (expdim_reg != 8'd0) begin
                        expdim_next = expdim_reg - ({3'b000, expdim_reg[7:3]} + 8'd1);
                    end
                    pwm_level_next = expdim_next;
                end
                STYLE_SINE_FAST: begin
                    pwm_level_next  = SINE_ROM[phase_fast_reg[15:8]];
                    phase_fast_next = phase_fast_reg + STEP_FAST;
                end
                STYLE_SINE_SLOW: begin
                    pwm_level_next  = SINE_ROM[phase_slow_reg[15:8]];
                    phase_slow_next = phase_slow_reg + STEP_SLOW;
                end
                STYLE_LOG: begin
                    pwm_level_next = LOG_ROM[log_step_reg];
                    if (log_step_reg != 8'd255) log_step_next = log_step_reg + 8'd1;
                end
                STYLE_STEPDIM: begin
                    if (stepdim_reg != 8'd0) begin
                        lfsr_next    = lfsr_step;
                        stepdim_next = (stepdim_reg > {3'b000, dim_step})
                                     ? stepdim_reg - {3'b000, dim_step} : 8'd0;
                    end
                    pwm_level_next = stepdim_next;
                end
                STYLE_ZIGZAG: begin
                    zigzag_next = zz_val;
                    if (zz_val == 8'd255) begin
                        zz_rising_next = 1'b0;
                    end else if (zz_val == 8'd0) begin
                        zz_rising_next = 1'b1;
                    end
                    pwm_level_next = zz_val;
                end
                default: begin
                    if (lindim_reg != 8'd0) lindim_next = lindim_reg - 8'd1;
                    pwm_level_next = lindim_next;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_level_reg  <= '0;
            tri_rising_reg <= 1'b1;
            expdim_reg     <= 8'd255;
            phase_fast_reg <= '0;
            phase_slow_reg <= '0;
            log_step_reg   <= '0;
            stepdim_reg    <= 8'd255;
            lfsr_reg       <= LFSR_SEED;
            zigzag_reg     <= '0;
            zz_rising_reg  <= 1'b1;
            lindim_reg     <= 8'd255;
        end else begin
            pwm_level_reg  <= pwm_level_next;
            tri_rising_reg <= tri_rising_next;
            expdim_reg     <= expdim_next;
            phase_fast_reg <= phase_fast_next;
            phase_slow_reg <= phase_slow_next;
            log_step_reg   <= log_step_next;
            stepdim_reg    <= stepdim_next;
            lfsr_reg       <= lfsr_next;
            zigzag_reg     <= zigzag_next;
            zz_rising_reg  <= zz_rising_next;
            lindim_reg     <= lindim_next;
        end
    end

    assign level_next = pwm_level_next;
    assign level      = pwm_level_reg;

endmodule

// ===== rtl/led_brightness_effect_generator_core.sv =====
// ----------------------------------------------------------------------------
// LED brightness effect generator core
// One channel: a tick divider fires the selected brightness effect and every
// tick transaction returns the current PWM level with an update flag.
//
//   channel   | dir | tdata bits
//   ----------+-----+------------------------------------------
//   s_axis    | in  | [0] tick, [7:1] zero
//   m_axis    | out | [7:0] pwm_value, [8] updated, [15:9] zero
//   cfg write | in  | index 0 refresh_period, 1 enabled, 2 style
//
// One tick transaction per cycle; its result is in the output register on
// the next cycle. Divider, style state and output register update in the
// same edge. A stalled output holds s_tready low until it is taken.
// Reset is synchronous and restores all effect state; the block is ready
// in the first cycle after reset.
// ----------------------------------------------------------------------------
module led_brightness_effect_generator_core
    import lbeg_pkg::*;
#(
    parameter int unsigned DIVIDER_BITS = 16
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [0] tick
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata     // [7:0] pwm_value, [8] updated
);

    localparam int unsigned CMP_W = (DIVIDER_BITS > PERIOD_W) ? DIVIDER_BITS : PERIOD_W;

    logic [PERIOD_W-1:0]     period_reg;
    logic                    enabled_reg;
    style_t                  style_reg;
    logic [DIVIDER_BITS-1:0] div_reg, div_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [LEVEL_W-1:0]      pwm_reg, pwm_next;
    logic                    updated_reg, updated_next;

    logic                    s_hs;
    logic                    tick;
    logic [DIVIDER_BITS-1:0] div_inc;
    logic                    fire;
    effect_ctrl_t            ctrl;
    logic [LEVEL_W-1:0]      level_next;
    logic [LEVEL_W-1:0]      level;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_hs     = s_tvalid && s_tready;
    assign tick     = s_tdata[0];

    always_comb begin
        div_inc = div_reg + 1'b1;
        fire    = s_hs && tick &&
                  (CMP_W'(div_inc) == CMP_W'(period_reg));
        div_next = div_reg;
        if (s_hs && tick) div_next = fire ? '0 : div_inc;
        ctrl.advance = fire && enabled_reg;
        ctrl.style   = style_reg;
    end

    lbeg_effect u_effect (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .level_next (level_next),
        .level      (level)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        pwm_next      = pwm_reg;
        updated_next  = updated_reg;
        if (s_hs) begin
            m_tvalid_next = 1'b1;
            pwm_next      = level_next;
            updated_next  = ctrl.advance;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= 16'd1;
            enabled_reg  <= 1'b0;
            style_reg    <= STYLE_TRIANGLE;
            div_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            div_reg      <= div_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_REFRESH_PERIOD:  period_reg  <= cfg_wdata;
                    REG_CHANNEL_ENABLED: enabled_reg <= cfg_wdata[0];
                    REG_EFFECT_STYLE:    style_reg   <= style_t'(cfg_wdata[2:0]);
                    default: ;
                endcase
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        pwm_reg     <= pwm_next;
        updated_reg <= updated_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0000000, updated_reg, pwm_reg};

    // An idle tick never reports an update
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_hs && !tick |=> !m_tdata[8])
        else $error("update flagged for an idle tick");

    // An idle tick returns the level held before it
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_hs && !tick |=> m_tdata[7:0] == $past(level))
        else $error("level changed on an idle tick");

    // Divider clears whenever it fires
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> div_reg == '0)
        else $error("divider not cleared after firing");

    // An advancing tick reports an update carrying the engine's new level
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_hs && ctrl.advance |=> m_tvalid && m_tdata[8] && m_tdata[7:0] == level)
        else $error("update result does not match engine level");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// LED brightness effect generator core testbench
// Drives tick transactions into the core and checks every returned PWM
// level and update flag against an in-bench model of the divider and the
// eight effect styles. Directed tests cover reset, each style, a disabled
// channel, the unused register index and periods 0 and 65535, which stay
// silent over a short run. A random part then runs phases of random settings
// with random gaps and stalls, and one test holds the result side off for a
// long stretch so that the core stalls its input.
// ----------------------------------------------------------------------------
module testbench;
    import lbeg_pkg::*;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS  = 720;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         DRAIN_CYCLES  = 4;

    typedef struct packed {
        logic [7:0] pwm_value;
        logic       updated;
    } pwm_result_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [1:0]          cfg_addr;
    logic [PERIOD_W-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;    // [0] tick
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;    // [7:0] pwm_value, [8] updated

    // Predicted results, oldest first
    pwm_result_t pending_levels[$];

    // Model configuration
    logic [15:0] cfg_period;
    logic        cfg_enable;
    style_t      cfg_style;

    // Model state
    logic [15:0] div_cnt;
    logic [7:0]  level;
    logic        tri_up;
    logic [7:0]  exp_lvl;
    logic [15:0] ph_fast;
    logic [15:0] ph_slow;
    logic [7:0]  log_idx;
    logic [7:0]  sd_lvl;
    logic [15:0] lfsr;
    logic [7:0]  zz_lvl;
    logic        zz_up;
    logic [7:0]  lin_lvl;

    int tx_gap_max;
    int rx_stall_max;
    int rx_hold_len;
    int fail_count;
    int n_ticks;
    int n_updates;

    led_brightness_effect_generator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Effect model
    // ------------------------------------------------------------------
    function automatic logic [7:0] sine_level(input logic [15:0] phase);
        logic [7:0]  idx;
        logic [5:0]  q;
        logic [1:0]  quad;
        int unsigned s;
        int unsigned v;
        // Quarter-wave table folded over four quadrants: the index is the top byte of the turn
        idx  = phase[15:8];
        q    = idx[5:0];
        quad = idx[7:6];
        s    = quad[0] ? int'(QUARTER_SINE[64 - int'(q)]) : int'(QUARTER_SINE[q]);
        v    = quad[1] ? (255 - s) >> 1 : (255 + s) >> 1;
        return v[7:0];
    endfunction

    function automatic logic [7:0] log_ramp_level(input int unsigned n);
        int unsigned     e;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned v;
        e = 0;
        while (e < 8 && (n >> (e + 1)) != 0) e++;
        m    = n;
        m    = m << (30 - e);
        frac = 0;
        for (int k = 0; k < 16; k++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        v = e;
        v = ((v << 16) | frac) * 255;
        v = v >> 19;
        return v[7:0];
    endfunction

    function automatic logic [7:0] advance_effect();
        logic [7:0]  v;
        int unsigned d;
        case (cfg_style)
            STYLE_TRIANGLE: begin
                if (tri_up) begin
                    v = level + 8'd1;
                    if (v == 8'hFF) tri_up = 1'b0;
                end else begin
                    v = level - 8'd1;
                    if (v == 8'h00) tri_up = 1'b1;
                end
            end
            STYLE_EXPDIM: begin
                if (exp_lvl != 0) exp_lvl = exp_lvl - ((exp_lvl >> 3) + 8'd1);
                v = exp_lvl;
            end
            STYLE_SINE_FAST: begin
                v       = sine_level(ph_fast);
                ph_fast = ph_fast + STEP_FAST;
            end
            STYLE_SINE_SLOW: begin
                v       = sine_level(ph_slow);
                ph_slow = ph_slow + STEP_SLOW;
            end
            STYLE_LOG: begin
                v = log_ramp_level(int'(log_idx) + 1);
                if (log_idx != 8'hFF) log_idx = log_idx + 8'd1;
            end
            STYLE_STEPDIM: begin
                // hold the LFSR once the level has reached zero
                if (sd_lvl != 0) begin
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
                    d    = (int'(lfsr) % 20) + 1;
                    sd_lvl = (int'(sd_lvl) > d) ? sd_lvl - 8'(d) : 8'd0;
                end
                v = sd_lvl;
            end
            STYLE_ZIGZAG: begin
                zz_lvl = zz_up ? zz_lvl + 8'd5 : zz_lvl - 8'd5;
                if (zz_lvl == 8'hFF) zz_up = 1'b0;
                else if (zz_lvl == 8'h00) zz_up = 1'b1;
                v = zz_lvl;
            end
            default: begin
                if (lin_lvl != 0) lin_lvl = lin_lvl - 8'd1;
                v = lin_lvl;
            end
        endcase
        return v;
    endfunction

    function automatic void predict_tick(input logic tick);
        pwm_result_t r;
        r.updated = 1'b0;
        if (tick) begin
            div_cnt = div_cnt + 16'd1;
            if (div_cnt == cfg_period) begin
                div_cnt = '0;
                if (cfg_enable) begin
                    level     = advance_effect();
                    r.updated = 1'b1;
                    n_updates++;
                end
            end
        end
        r.pwm_value = level;
        pending_levels.push_back(r);
        n_ticks++;
    endfunction

    function automatic void reset_model();
        cfg_period = 16'd1;
        cfg_enable = 1'b0;
        cfg_style  = STYLE_TRIANGLE;
        div_cnt    = '0;
        level      = '0;
        tri_up     = 1'b1;
        exp_lvl    = 8'hFF;
        ph_fast    = '0;
        ph_slow    = '0;
        log_idx    = '0;
        sd_lvl     = 8'hFF;
        lfsr       = LFSR_SEED;
        zz_lvl     = '0;
        zz_up      = 1'b1;
        lin_lvl    = 8'hFF;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_tick(input logic tick);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick};
        do @(posedge aclk); while (!s_tready);
        predict_tick(tick);
    endtask

    // call in the step of the last transaction
    task automatic idle_input();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            REG_REFRESH_PERIOD:  cfg_period = data;
            REG_CHANNEL_ENABLED: cfg_enable = data[0];
            REG_EFFECT_STYLE:    cfg_style  = style_t'(data[2:0]);
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] period, input logic en, input style_t st);
        logic [15:0] noise;
        wait_drain();
        noise = 16'($urandom);
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_REFRESH_PERIOD, period);
        write_reg(REG_CHANNEL_ENABLED, {noise[15:1], en});
        write_reg(REG_EFFECT_STYLE, {noise[15:3], st});
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_and_disabled();
        // reset settings: period 1, channel off
        send_tick(1'b0);
        send_tick(1'b1);
        idle_input();
        configure(16'd2, 1'b0, STYLE_LINDIM);
        repeat (3) send_tick(1'b1);
        idle_input();
    endtask

    task automatic test_each_style();
        style_t all_styles[8];
        all_styles = '{STYLE_TRIANGLE, STYLE_EXPDIM, STYLE_SINE_FAST, STYLE_SINE_SLOW,
                       STYLE_LOG, STYLE_STEPDIM, STYLE_ZIGZAG, STYLE_LINDIM};
        foreach (all_styles[i]) begin
            configure(div_cnt + 16'd1, 1'b1, all_styles[i]);
            send_tick(1'b1);
            send_tick(1'b1);
            if (i == 0) send_tick(1'b0);
            idle_input();
        end
    endtask

    task automatic test_large_periods();
        // period 0 waits for a full divider wrap and 65535 for a full count,
        // so neither fires within a short run
        configure(16'd0, 1'b1, STYLE_LINDIM);
        repeat (20) send_tick(1'b1);
        idle_input();
        configure(16'hFFFF, 1'b1, STYLE_ZIGZAG);
        repeat (20) send_tick(1'b1);
        idle_input();
    endtask

    task automatic test_random_phases();
        int     sent;
        int     run_len;
        logic   en;
        style_t st;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                tx_gap_max   = 0;
                rx_stall_max = 0;
            end else begin
                tx_gap_max   = 6;
                rx_stall_max = 6;
            end
            en = ($urandom_range(0, 9) != 0);
            st = style_t'(3'($urandom_range(0, 7)));
            // keep the period above the divider so the effect keeps firing
            configure(div_cnt + 16'($urandom_range(1, 3)), en, st);
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 320)
                                                  : $urandom_range(10, 60);
            repeat (run_len) send_tick($urandom_range(0, 9) != 0);
            idle_input();
            sent += run_len;
        end
        tx_gap_max   = 6;
        rx_stall_max = 6;
    endtask

    task automatic test_output_backpressure();
        configure(div_cnt + 16'd1, 1'b1, STYLE_SINE_FAST);
        tx_gap_max  = 0;
        rx_hold_len = HOLD_CYCLES;
        repeat (40) send_tick(1'b1);
        idle_input();
        tx_gap_max = 6;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    initial begin
        int n;
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_len > 0) begin
                n           = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                n = $urandom_range(0, rx_stall_max);
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        pwm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                $error("unexpected result: pwm_value %0d updated %0d",
                       m_tdata[7:0], m_tdata[8]);
                fail_count++;
            end else begin
                want = pending_levels.pop_front();
                if (m_tdata[7:0] !== want.pwm_value) begin
                    $error("pwm_value: expected %0d, got %0d", want.pwm_value, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[8] !== want.updated) begin
                    $error("updated: expected %0d, got %0d", want.updated, m_tdata[8]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = REG_REFRESH_PERIOD;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tx_gap_max   = 6;
        rx_stall_max = 6;
        rx_hold_len  = 0;
        fail_count   = 0;
        n_ticks      = 0;
        n_updates    = 0;
        reset_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_and_disabled();
        test_each_style();
        test_large_periods();
        test_random_phases();
        test_output_backpressure();
        wait_drain();

        $display("run covered %0d tick transactions and %0d effect updates", n_ticks, n_updates);
        $display("all eight styles, channel off, periods 0 and 65535, random gaps, long stall");
        if (fail_count == 0) begin
            $display("led_brightness_effect_generator_core: match");
        end else begin
            $display("led_brightness_effect_generator_core: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("led_brightness_effect_generator_core: mismatch");
        $finish;
    end

endmodule
